// File: rtl/nmt_pkg.sv
// Shared types, constants and controller/datapath interface of the NAT mapping table.
package nmt_pkg;

  localparam int MAP_ENTRIES     = 64;
  localparam int RECORDS_PER_MAP = 8;
  localparam int MAP_AW          = $clog2(MAP_ENTRIES);
  localparam int REC_AW          = $clog2(RECORDS_PER_MAP);
  localparam int SOCK_W          = 12;
  localparam int POOL_WORD_W     = 64;
  localparam int BIT_W           = $clog2(POOL_WORD_W);
  localparam int POOL_WORDS      = 4096 / POOL_WORD_W;
  localparam int POOL_AW         = $clog2(POOL_WORDS);
  localparam int IP_SEL_W        = 4;
  localparam int PORT_SEL_W      = 8;
  localparam int WSEL_W          = PORT_SEL_W - BIT_W;
  localparam logic [4:0] IP_SLOTS   = 5'd16;
  localparam logic [8:0] PORT_SLOTS = 9'd256;

  localparam logic [2:0] CFG_TIMEOUT    = 3'd0;
  localparam logic [2:0] CFG_IP_BASE    = 3'd1;
  localparam logic [2:0] CFG_IP_COUNT   = 3'd2;
  localparam logic [2:0] CFG_PORT_BASE  = 3'd3;
  localparam logic [2:0] CFG_PORT_COUNT = 3'd4;

  typedef enum logic [1:0] {
    OP_OUT   = 2'd0,
    OP_IN    = 2'd1,
    OP_TICK  = 2'd2,
    OP_SWEEP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_NO_SOCKET = 3'd2,
    ST_MAP_FULL  = 3'd3,
    ST_REC_FULL  = 3'd4
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] local_ip;
    logic [15:0] local_port;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
    logic [31:0] nat_ip;
    logic [15:0] nat_port;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] result_ip;
    logic [15:0] result_port;
  } out_item_t;

  typedef struct packed {
    logic [31:0]       lip;
    logic [15:0]       lport;
    logic [31:0]       rip;
    logic [SOCK_W-1:0] sock;
  } map_ent_t;

  typedef struct packed {
    logic [15:0] port;
    logic [31:0] stamp;
  } rec_ent_t;

  typedef struct packed {
    logic              cap;
    logic              tick;
    logic              map_rd;
    logic              rec_rd;
    logic              pool_rd;
    logic              pool_rd_sock;
    logic              rec_exp_clr;
    logic              free;
    logic              lat_found;
    logic              lat_pool;
    logic              alloc;
    logic              rec_add;
    logic              lat_local;
    logic              emit;
    status_t           stat;
    logic [MAP_AW-1:0] m;
    logic [REC_AW-1:0] r;
    logic [IP_SEL_W-1:0] pi;
    logic [WSEL_W-1:0] pw;
  } dp_cmd_t;

  typedef struct packed {
    op_t                        op;
    logic                       map_v;
    logic [RECORDS_PER_MAP-1:0] rec_row;
    logic                       key_match;
    logic                       pool_hit;
    logic                       rport_match;
    logic                       ib_match;
    logic [4:0]                 ipc;
    logic [8:0]                 ppc;
    logic                       out_busy;
  } dp_stat_t;

endpackage

// File: rtl/nmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/nmt_dp.sv
// Datapath of the NAT mapping table: storage, configuration, compares and result register.
module nmt_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  nmt_pkg::in_item_t  in_data,
  input  nmt_pkg::dp_cmd_t   cmd,
  output nmt_pkg::dp_stat_t  st,
  output logic               out_valid,
  input  logic               out_stall,
  output nmt_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import nmt_pkg::*;

  in_item_t                   item_r;
  logic [31:0]                now_r;
  logic [31:0]                tmo_r;
  logic [31:0]                ipb_r;
  logic [4:0]                 ipc_r;
  logic [15:0]                ppb_r;
  logic [8:0]                 ppc_r;
  logic [MAP_ENTRIES-1:0]     map_v_r;
  logic [RECORDS_PER_MAP-1:0] rec_v_r [MAP_ENTRIES];
  logic [POOL_WORDS-1:0]      pool_wv_r;
  logic [SOCK_W-1:0]          sock_r;
  logic [POOL_WORD_W-1:0]     pword_r;
  logic [POOL_AW-1:0]         pool_ra_r;
  logic [31:0]                loc_ip_r;
  logic [15:0]                loc_port_r;
  out_item_t                  out_r;
  logic                       out_valid_r;

  map_ent_t               map_rd;
  map_ent_t               map_wd;
  rec_ent_t               rec_rd;
  rec_ent_t               rec_wd;
  logic [POOL_WORD_W-1:0] pool_rd;
  logic [POOL_WORD_W-1:0] pool_word;
  logic [POOL_WORD_W-1:0] pool_wd;
  logic [POOL_WORD_W-1:0] bit_mask;
  logic [POOL_WORD_W-1:0] port_mask;
  logic [POOL_WORD_W-1:0] free_bits;
  logic [BIT_W-1:0]       free_enc;
  logic                   pool_re;
  logic                   pool_we;
  logic [POOL_AW-1:0]     pool_raddr;
  logic [4:0]             ipc_sat;
  logic [8:0]             ppc_sat;
  logic                   expired;
  logic [31:0]            sock_ip;
  logic [15:0]            sock_port;

  assign ipc_sat = (ipc_r > IP_SLOTS) ? IP_SLOTS : ipc_r;
  assign ppc_sat = (ppc_r > PORT_SLOTS) ? PORT_SLOTS : ppc_r;

  assign map_wd = '{lip: item_r.local_ip, lport: item_r.local_port,
                    rip: item_r.remote_ip, sock: sock_r};
  assign rec_wd = '{port: item_r.remote_port, stamp: now_r};

  nmt_ram #(.WIDTH($bits(map_ent_t)), .DEPTH(MAP_ENTRIES)) u_map_ram (
    .clk   (clk),
    .we    (cmd.alloc),
    .waddr (cmd.m),
    .wdata (map_wd),
    .re    (cmd.map_rd),
    .raddr (cmd.m),
    .rdata (map_rd)
  );

  nmt_ram #(.WIDTH($bits(rec_ent_t)), .DEPTH(MAP_ENTRIES * RECORDS_PER_MAP)) u_rec_ram (
    .clk   (clk),
    .we    (cmd.rec_add),
    .waddr ({cmd.m, cmd.r}),
    .wdata (rec_wd),
    .re    (cmd.rec_rd),
    .raddr ({cmd.m, cmd.r}),
    .rdata (rec_rd)
  );

  assign pool_re    = cmd.pool_rd | cmd.pool_rd_sock;
  assign pool_raddr = cmd.pool_rd_sock ? map_rd.sock[SOCK_W-1 -: POOL_AW] : {cmd.pi, cmd.pw};
  assign pool_we    = cmd.alloc | cmd.free;
  assign bit_mask   = POOL_WORD_W'(1) << sock_r[BIT_W-1:0];
  assign pool_word  = pool_wv_r[pool_ra_r] ? pool_rd : '0;
  assign pool_wd    = cmd.alloc ? (pword_r | bit_mask) : (pool_word & ~bit_mask);

  nmt_ram #(.WIDTH(POOL_WORD_W), .DEPTH(POOL_WORDS)) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (sock_r[SOCK_W-1 -: POOL_AW]),
    .wdata (pool_wd),
    .re    (pool_re),
    .raddr (pool_raddr),
    .rdata (pool_rd)
  );

  always_comb begin
    free_enc = '0;
    for (int b = 0; b < POOL_WORD_W; b++) begin
      port_mask[b] = {1'b0, pool_ra_r[WSEL_W-1:0], BIT_W'(b)} < ppc_sat;
    end
    free_bits = ~pool_word & port_mask;
    for (int b = POOL_WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        free_enc = BIT_W'(b);
      end
    end
  end

  assign sock_ip   = ipb_r + 32'(map_rd.sock[SOCK_W-1 -: IP_SEL_W]);
  assign sock_port = ppb_r + 16'(map_rd.sock[PORT_SEL_W-1:0]);
  assign expired   = (now_r - rec_rd.stamp) >= tmo_r;

  assign st.op          = item_r.op;
  assign st.map_v       = map_v_r[cmd.m];
  assign st.rec_row     = rec_v_r[cmd.m];
  assign st.key_match   = (map_rd.lip == item_r.local_ip) && (map_rd.lport == item_r.local_port)
                          && (map_rd.rip == item_r.remote_ip);
  assign st.pool_hit    = |free_bits;
  assign st.rport_match = rec_rd.port == item_r.remote_port;
  assign st.ib_match    = (map_rd.rip == item_r.remote_ip) && (sock_ip == item_r.nat_ip)
                          && (sock_port == item_r.nat_port);
  assign st.ipc         = ipc_sat;
  assign st.ppc         = ppc_sat;
  assign st.out_busy    = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      tmo_r       <= 32'd300;
      ipb_r       <= '0;
      ipc_r       <= '0;
      ppb_r       <= 16'd1024;
      ppc_r       <= '0;
      map_v_r     <= '0;
      pool_wv_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        rec_v_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT:    tmo_r <= cfg_wdata;
          CFG_IP_BASE:    ipb_r <= cfg_wdata;
          CFG_IP_COUNT:   ipc_r <= cfg_wdata[4:0];
          CFG_PORT_BASE:  ppb_r <= cfg_wdata[15:0];
          CFG_PORT_COUNT: ppc_r <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (cmd.tick) begin
        now_r <= now_r + 32'd1;
      end
      if (cmd.rec_exp_clr && expired) begin
        rec_v_r[cmd.m][cmd.r] <= 1'b0;
      end
      if (cmd.rec_add) begin
        rec_v_r[cmd.m][cmd.r] <= 1'b1;
      end
      if (cmd.alloc) begin
        map_v_r[cmd.m] <= 1'b1;
      end
      if (cmd.free) begin
        map_v_r[cmd.m] <= 1'b0;
      end
      if (pool_we) begin
        pool_wv_r[sock_r[SOCK_W-1 -: POOL_AW]] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item_r <= in_data;
    end
    if (pool_re) begin
      pool_ra_r <= pool_raddr;
    end
    if (cmd.lat_found || cmd.pool_rd_sock) begin
      sock_r <= map_rd.sock;
    end
    if (cmd.lat_pool) begin
      sock_r  <= {pool_ra_r, free_enc};
      pword_r <= pool_word;
    end
    if (cmd.lat_local) begin
      loc_ip_r   <= map_rd.lip;
      loc_port_r <= map_rd.lport;
    end
    if (cmd.emit) begin
      out_r.status <= cmd.stat;
      if (cmd.stat != ST_OK) begin
        out_r.result_ip   <= '0;
        out_r.result_port <= '0;
      end else if (item_r.op == OP_OUT) begin
        out_r.result_ip   <= ipb_r + 32'(sock_r[SOCK_W-1 -: IP_SEL_W]);
        out_r.result_port <= ppb_r + 16'(sock_r[PORT_SEL_W-1:0]);
      end else begin
        out_r.result_ip   <= loc_ip_r;
        out_r.result_port <= loc_port_r;
      end
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result emitted over a stalled beat");
  a_alloc_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !map_v_r[cmd.m] && (rec_v_r[cmd.m] == '0))
    else $error("allocation into a live mapping slot");
  a_free_norec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.free |-> map_v_r[cmd.m] && (rec_v_r[cmd.m] == '0))
    else $error("mapping freed while records remain");
  a_add_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec_add |-> map_v_r[cmd.m] && !rec_v_r[cmd.m][cmd.r])
    else $error("record added over a valid record");

endmodule

// File: rtl/nmt_ctrl.sv
// Controller of the NAT mapping table: sweep, lookup, allocation and result sequencing.
module nmt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  nmt_pkg::op_t      in_op,
  output logic              in_stall,
  output nmt_pkg::dp_cmd_t  cmd,
  input  nmt_pkg::dp_stat_t st
);
  import nmt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SW_MAP, S_SW_REC, S_SW_CHK, S_SW_END, S_SW_FR1, S_SW_FR2,
    S_OB_SCAN, S_OB_CMP, S_OB_POOL, S_OB_PCHK, S_OB_ALLOC, S_OB_REC, S_OB_RCMP,
    S_OB_ADD, S_IB_SCAN, S_IB_CMP, S_IB_REC, S_IB_RCMP, S_DONE
  } state_t;

  localparam logic [MAP_AW-1:0] LAST_M = MAP_AW'(MAP_ENTRIES - 1);
  localparam logic [REC_AW-1:0] LAST_R = REC_AW'(RECORDS_PER_MAP - 1);

  state_t              state_r, state_nxt;
  logic [MAP_AW-1:0]   m_r, m_nxt;
  logic [REC_AW-1:0]   r_r, r_nxt;
  logic [IP_SEL_W-1:0] pi_r, pi_nxt;
  logic [WSEL_W-1:0]   pw_r, pw_nxt;
  logic [MAP_AW-1:0]   free_m_r, free_m_nxt;
  logic                has_free_r, has_free_nxt;
  status_t             stat_r, stat_nxt;

  logic              sw_next;
  logic              ib_next;
  logic              pool_start;
  logic              ob_rec_end;
  logic [REC_AW-1:0] slot;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    slot = '0;
    for (int i = RECORDS_PER_MAP - 1; i >= 0; i--) begin
      if (!st.rec_row[i]) begin
        slot = REC_AW'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    m_nxt        = m_r;
    r_nxt        = r_r;
    pi_nxt       = pi_r;
    pw_nxt       = pw_r;
    free_m_nxt   = free_m_r;
    has_free_nxt = has_free_r;
    stat_nxt     = stat_r;
    sw_next      = 1'b0;
    ib_next      = 1'b0;
    pool_start   = 1'b0;
    ob_rec_end   = 1'b0;
    cmd          = '0;
    cmd.m        = m_r;
    cmd.r        = r_r;
    cmd.pi       = pi_r;
    cmd.pw       = pw_r;
    cmd.stat     = stat_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          if (in_op == OP_TICK) begin
            cmd.tick = 1'b1;
          end else begin
            m_nxt     = '0;
            state_nxt = S_SW_MAP;
          end
        end
      end
      S_SW_MAP: begin
        if (st.map_v) begin
          r_nxt     = '0;
          state_nxt = S_SW_REC;
        end else begin
          sw_next = 1'b1;
        end
      end
      S_SW_REC: begin
        if (st.rec_row[r_r]) begin
          cmd.rec_rd = 1'b1;
          state_nxt  = S_SW_CHK;
        end else if (r_r == LAST_R) begin
          state_nxt = S_SW_END;
        end else begin
          r_nxt = r_r + REC_AW'(1);
        end
      end
      S_SW_CHK: begin
        cmd.rec_exp_clr = 1'b1;
        if (r_r == LAST_R) begin
          state_nxt = S_SW_END;
        end else begin
          r_nxt     = r_r + REC_AW'(1);
          state_nxt = S_SW_REC;
        end
      end
      S_SW_END: begin
        if (st.rec_row == '0) begin
          cmd.map_rd = 1'b1;
          state_nxt  = S_SW_FR1;
        end else begin
          sw_next = 1'b1;
        end
      end
      S_SW_FR1: begin
        cmd.pool_rd_sock = 1'b1;
        state_nxt        = S_SW_FR2;
      end
      S_SW_FR2: begin
        cmd.free = 1'b1;
        sw_next  = 1'b1;
      end
      S_OB_SCAN: begin
        if (st.map_v) begin
          cmd.map_rd = 1'b1;
          state_nxt  = S_OB_CMP;
        end else begin
          if (!has_free_r) begin
            free_m_nxt   = m_r;
            has_free_nxt = 1'b1;
          end
          if (m_r == LAST_M) begin
            pool_start = 1'b1;
          end else begin
            m_nxt = m_r + MAP_AW'(1);
          end
        end
      end
      S_OB_CMP: begin
        if (st.key_match) begin
          cmd.lat_found = 1'b1;
          r_nxt         = '0;
          state_nxt     = S_OB_REC;
        end else if (m_r == LAST_M) begin
          pool_start = 1'b1;
        end else begin
          m_nxt     = m_r + MAP_AW'(1);
          state_nxt = S_OB_SCAN;
        end
      end
      S_OB_POOL: begin
        cmd.pool_rd = 1'b1;
        state_nxt   = S_OB_PCHK;
      end
      S_OB_PCHK: begin
        if (st.pool_hit) begin
          cmd.lat_pool = 1'b1;
          if (has_free_r) begin
            state_nxt = S_OB_ALLOC;
          end else begin
            stat_nxt  = ST_MAP_FULL;
            state_nxt = S_DONE;
          end
        end else if ({({1'b0, pw_r} + 3'd1), 6'd0} < st.ppc) begin
          pw_nxt    = pw_r + WSEL_W'(1);
          state_nxt = S_OB_POOL;
        end else if (({1'b0, pi_r} + 5'd1) < st.ipc) begin
          pi_nxt    = pi_r + IP_SEL_W'(1);
          pw_nxt    = '0;
          state_nxt = S_OB_POOL;
        end else begin
          stat_nxt  = ST_NO_SOCKET;
          state_nxt = S_DONE;
        end
      end
      S_OB_ALLOC: begin
        cmd.m     = free_m_r;
        cmd.alloc = 1'b1;
        m_nxt     = free_m_r;
        r_nxt     = '0;
        state_nxt = S_OB_REC;
      end
      S_OB_REC: begin
        if (st.rec_row[r_r]) begin
          cmd.rec_rd = 1'b1;
          state_nxt  = S_OB_RCMP;
        end else if (r_r == LAST_R) begin
          ob_rec_end = 1'b1;
        end else begin
          r_nxt = r_r + REC_AW'(1);
        end
      end
      S_OB_RCMP: begin
        if (st.rport_match) begin
          stat_nxt  = ST_OK;
          state_nxt = S_DONE;
        end else if (r_r == LAST_R) begin
          ob_rec_end = 1'b1;
        end else begin
          r_nxt     = r_r + REC_AW'(1);
          state_nxt = S_OB_REC;
        end
      end
      S_OB_ADD: begin
        cmd.r       = slot;
        cmd.rec_add = 1'b1;
        stat_nxt    = ST_OK;
        state_nxt   = S_DONE;
      end
      S_IB_SCAN: begin
        if (st.map_v) begin
          cmd.map_rd = 1'b1;
          state_nxt  = S_IB_CMP;
        end else begin
          ib_next = 1'b1;
        end
      end
      S_IB_CMP: begin
        if (st.ib_match) begin
          cmd.lat_local = 1'b1;
          r_nxt         = '0;
          state_nxt     = S_IB_REC;
        end else begin
          ib_next = 1'b1;
        end
      end
      S_IB_REC: begin
        if (st.rec_row[r_r]) begin
          cmd.rec_rd = 1'b1;
          state_nxt  = S_IB_RCMP;
        end else if (r_r == LAST_R) begin
          ib_next = 1'b1;
        end else begin
          r_nxt = r_r + REC_AW'(1);
        end
      end
      S_IB_RCMP: begin
        if (st.rport_match) begin
          stat_nxt  = ST_OK;
          state_nxt = S_DONE;
        end else if (r_r == LAST_R) begin
          ib_next = 1'b1;
        end else begin
          r_nxt     = r_r + REC_AW'(1);
          state_nxt = S_IB_REC;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (sw_next) begin
      if (m_r == LAST_M) begin
        m_nxt = '0;
        case (st.op)
          OP_SWEEP: state_nxt = S_IDLE;
          OP_OUT: begin
            has_free_nxt = 1'b0;
            state_nxt    = S_OB_SCAN;
          end
          default: state_nxt = S_IB_SCAN;
        endcase
      end else begin
        m_nxt     = m_r + MAP_AW'(1);
        state_nxt = S_SW_MAP;
      end
    end

    if (ib_next) begin
      if (m_r == LAST_M) begin
        stat_nxt  = ST_NOT_FOUND;
        state_nxt = S_DONE;
      end else begin
        m_nxt     = m_r + MAP_AW'(1);
        state_nxt = S_IB_SCAN;
      end
    end

    if (pool_start) begin
      if ((st.ipc == '0) || (st.ppc == '0)) begin
        stat_nxt  = ST_NO_SOCKET;
        state_nxt = S_DONE;
      end else begin
        pi_nxt    = '0;
        pw_nxt    = '0;
        state_nxt = S_OB_POOL;
      end
    end

    if (ob_rec_end) begin
      if (st.rec_row != '1) begin
        state_nxt = S_OB_ADD;
      end else begin
        stat_nxt  = ST_REC_FULL;
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      m_r        <= '0;
      r_r        <= '0;
      pi_r       <= '0;
      pw_r       <= '0;
      free_m_r   <= '0;
      has_free_r <= 1'b0;
      stat_r     <= ST_OK;
    end else begin
      state_r    <= state_nxt;
      m_r        <= m_nxt;
      r_r        <= r_nxt;
      pi_r       <= pi_nxt;
      pw_r       <= pw_nxt;
      free_m_r   <= free_m_nxt;
      has_free_r <= has_free_nxt;
      stat_r     <= stat_nxt;
    end
  end

  a_alloc_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OB_ALLOC) |-> has_free_r)
    else $error("allocation without a free mapping slot");
  a_done_ok_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after a result");
  a_tick_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick |-> (state_r == S_IDLE) && (state_nxt == S_IDLE))
    else $error("tick taken outside idle");

endmodule

// File: rtl/nat_mapping_table.sv
// Top level of the NAT mapping table: controller and datapath.
// A tick beat is handled in idle. Every other beat first sweeps the 64 mappings,
// checking each valid record of a live mapping for expiry and freeing a mapping left
// with no records; an outbound beat then scans the mappings, the socket pool one
// 64-port word at a time, and the eight record slots of the chosen mapping, and may
// allocate a mapping and add a record; an inbound beat scans mappings and matching
// records the same way. The mapping and record memories each have one read port;
// a result is registered and the block takes a new beat once it is issued.
// No clearing pass follows reset.
module nat_mapping_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  nmt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output nmt_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import nmt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  nmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  nmt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
